// ===== rtl/multi_key_press_event_detector_unit_macros.svh =====
// Assertion helpers for the key event detector.
// Each macro samples on the rising clock edge and is disabled during reset.
`ifndef MULTI_KEY_PRESS_EVENT_DETECTOR_UNIT_MACROS_SVH
`define MULTI_KEY_PRESS_EVENT_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define MKPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key event detector check failed");

// Next-cycle implication.
`define MKPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key event detector check failed");

`endif

// ===== rtl/mkpd_pkg.sv =====
package mkpd_pkg;

  // Action codes carried by an input transaction.
  typedef enum logic [1:0] {
    ACT_SCAN      = 2'd0,
    ACT_QUERY     = 2'd1,
    ACT_CLEAR_ONE = 2'd2,
    ACT_CLEAR_ALL = 2'd3
  } action_e;

  // Per-key event state.
  typedef enum logic [1:0] {
    EV_IDLE    = 2'd0,
    EV_READY   = 2'd1,
    EV_PENDING = 2'd2
  } event_e;

  // Event kinds that a query can name.
  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_LONG    = 3'd1;
  localparam logic [2:0] KIND_REPEAT  = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_STATUS  = 3'd4;

  // Field widths.
  localparam int unsigned ActionW  = 2;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned IndexW   = 2;
  localparam int unsigned KindW    = 3;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 4;

  // Configuration register indexes and reset values.
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_REPEAT     = 4'd1;
  localparam logic [CountW-1:0]  LongResetVal   = 16'd100;
  localparam logic [CountW-1:0]  RepeatResetVal = 16'd10;

  // Per-key command decoded from one accepted transaction.
  typedef struct packed {
    logic             scan;
    logic             level;
    logic             query;
    logic             clear;
    logic [KindW-1:0] kind;
  } lane_ctrl_t;

endpackage

// ===== rtl/mkpd_key_lane.sv =====
module mkpd_key_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mkpd_pkg::lane_ctrl_t        ctrl_i,
  input  logic [mkpd_pkg::CountW-1:0] long_ticks_i,
  input  logic [mkpd_pkg::CountW-1:0] repeat_ticks_i,
  output logic                        hit_o
);

  logic                        down_q, down_d;
  logic [mkpd_pkg::CountW-1:0] hold_q, hold_d;
  logic [mkpd_pkg::CountW-1:0] rep_q, rep_d;
  mkpd_pkg::event_e            press_q, press_d;
  mkpd_pkg::event_e            rel_q, rel_d;
  mkpd_pkg::event_e            long_q, long_d;
  logic                        rrdy_q, rrdy_d;

  // Next state of this key for the current transaction.
  always_comb begin
    down_d  = down_q;
    hold_d  = hold_q;
    rep_d   = rep_q;
    press_d = press_q;
    rel_d   = rel_q;
    long_d  = long_q;
    rrdy_d  = rrdy_q;
    hit_o   = 1'b0;

    if (ctrl_i.scan) begin
      if (ctrl_i.level) begin
        down_d = 1'b1;
        if (!down_q && press_q == mkpd_pkg::EV_IDLE) begin
          rel_d   = mkpd_pkg::EV_IDLE;
          press_d = mkpd_pkg::EV_READY;
        end
        // Hold counter saturates at the long-press limit.
        if (hold_q < long_ticks_i) begin
          hold_d = hold_q + 1'b1;
        end else if (long_q == mkpd_pkg::EV_IDLE) begin
          long_d = mkpd_pkg::EV_READY;
        end
        // Auto-repeat runs only once long-press has fired.
        if (long_d != mkpd_pkg::EV_IDLE) begin
          if (rep_q < repeat_ticks_i) begin
            rep_d = rep_q + 1'b1;
          end else begin
            rrdy_d = 1'b1;
          end
        end
      end else begin
        if (down_q) begin
          down_d = 1'b0;
          rel_d  = mkpd_pkg::EV_READY;
        end
        hold_d  = '0;
        rep_d   = '0;
        press_d = mkpd_pkg::EV_IDLE;
        long_d  = mkpd_pkg::EV_IDLE;
        rrdy_d  = 1'b0;
      end
    end else if (ctrl_i.query) begin
      // A ready press, long or release event goes pending.
      case (ctrl_i.kind)
        mkpd_pkg::KIND_PRESS: begin
          if (press_q == mkpd_pkg::EV_READY) begin
            press_d = mkpd_pkg::EV_PENDING;
            hit_o   = 1'b1;
          end
        end
        mkpd_pkg::KIND_LONG: begin
          if (long_q == mkpd_pkg::EV_READY) begin
            long_d = mkpd_pkg::EV_PENDING;
            hit_o  = 1'b1;
          end
        end
        mkpd_pkg::KIND_REPEAT: begin
          if (rrdy_q) begin
            rrdy_d = 1'b0;
            rep_d  = '0;
            hit_o  = 1'b1;
          end
        end
        mkpd_pkg::KIND_RELEASE: begin
          if (rel_q == mkpd_pkg::EV_READY) begin
            rel_d = mkpd_pkg::EV_PENDING;
            hit_o = 1'b1;
          end
        end
        mkpd_pkg::KIND_STATUS: begin
          hit_o = !down_q;
        end
        default: begin
          hit_o = 1'b0;
        end
      endcase
    end else if (ctrl_i.clear) begin
      // Clearing keeps the pressed flag.
      hold_d  = '0;
      rep_d   = '0;
      press_d = mkpd_pkg::EV_IDLE;
      rel_d   = mkpd_pkg::EV_IDLE;
      long_d  = mkpd_pkg::EV_IDLE;
      rrdy_d  = 1'b0;
    end
  end

  // Key state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= 1'b0;
      hold_q  <= '0;
      rep_q   <= '0;
      press_q <= mkpd_pkg::EV_IDLE;
      rel_q   <= mkpd_pkg::EV_IDLE;
      long_q  <= mkpd_pkg::EV_IDLE;
      rrdy_q  <= 1'b0;
    end else begin
      down_q  <= down_d;
      hold_q  <= hold_d;
      rep_q   <= rep_d;
      press_q <= press_d;
      rel_q   <= rel_d;
      long_q  <= long_d;
      rrdy_q  <= rrdy_d;
    end
  end

endmodule

// ===== rtl/mkpd_merge.sv =====
module mkpd_merge #(
  parameter int unsigned KeyCount = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [KeyCount-1:0] lane_hit_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                event_hit_o
);

  logic       head_q, head_d;
  logic       tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;
  logic       hit;
  logic       pop;

  // Only the addressed lane can report a hit, so an OR merges the lanes.
  assign hit = |lane_hit_i;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign space_o     = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign event_hit_o = head_q;

  // Two-entry result buffer.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (pop) begin
      head_d = (cnt_q == 2'd2) ? tail_q : hit;
      if (cnt_q == 2'd2 && push_i) begin
        tail_d = hit;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_d = hit;
      end else begin
        tail_d = hit;
      end
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Buffer occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Buffer data.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// ===== rtl/multi_key_press_event_detector_unit.sv =====
// Key event detector: tracks KEY_COUNT push keys and reports press, release,
// long-press and auto-repeat events. Every transaction (scan tick, query or
// clear) is handled by one lane per key working in parallel, so the block
// takes one transaction per cycle while the buffer has space; the result is
// registered in a two-entry output buffer that stalls input only when both
// entries are waiting. Keys at index four and above always scan as released.
// Configuration writes take effect on the next cycle and cfg_ready_o is
// always high.
module multi_key_press_event_detector_unit #(
  parameter int unsigned KEY_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mkpd_pkg::ActionW-1:0]  action_i,
  input  logic [mkpd_pkg::LevelW-1:0]   key_levels_i,
  input  logic [mkpd_pkg::IndexW-1:0]   key_index_i,
  input  logic [mkpd_pkg::KindW-1:0]    event_kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          event_hit_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mkpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mkpd_pkg::CountW-1:0]   cfg_data_i
);

  logic                        in_acc;
  logic                        space;
  mkpd_pkg::action_e           action;
  logic [mkpd_pkg::CountW-1:0] long_ticks_q;
  logic [mkpd_pkg::CountW-1:0] repeat_ticks_q;
  mkpd_pkg::lane_ctrl_t        lane_ctrl [KEY_COUNT];
  logic [KEY_COUNT-1:0]        lane_hit;

  assign in_ready_o  = space;
  assign in_acc      = in_valid_i && space;
  assign action      = mkpd_pkg::action_e'(action_i);
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= mkpd_pkg::LongResetVal;
      repeat_ticks_q <= mkpd_pkg::RepeatResetVal;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mkpd_pkg::REG_LONG_PRESS: long_ticks_q   <= cfg_data_i;
        mkpd_pkg::REG_REPEAT:     repeat_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One lane per key.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    logic sel;
    assign sel = (32'(key_index_i) == 32'(k));

    // Keys beyond the level field never scan as pressed.
    if (k < mkpd_pkg::LevelW) begin : g_level
      assign lane_ctrl[k].level = key_levels_i[k];
    end else begin : g_nolevel
      assign lane_ctrl[k].level = 1'b0;
    end

    assign lane_ctrl[k].scan  = in_acc && (action == mkpd_pkg::ACT_SCAN);
    assign lane_ctrl[k].query = in_acc && (action == mkpd_pkg::ACT_QUERY) && sel;
    assign lane_ctrl[k].clear = in_acc && ((action == mkpd_pkg::ACT_CLEAR_ALL) ||
                                ((action == mkpd_pkg::ACT_CLEAR_ONE) && sel));
    assign lane_ctrl[k].kind  = event_kind_i;

    mkpd_key_lane u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (lane_ctrl[k]),
      .long_ticks_i   (long_ticks_q),
      .repeat_ticks_i (repeat_ticks_q),
      .hit_o          (lane_hit[k])
    );
  end

  // Merge lane results into the output buffer.
  mkpd_merge #(
    .KeyCount (KEY_COUNT)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .lane_hit_i  (lane_hit),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_hit_o (event_hit_o)
  );

endmodule

// ===== rtl/mkpd_checker.sv =====
`include "multi_key_press_event_detector_unit_macros.svh"

module mkpd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [mkpd_pkg::ActionW-1:0] action_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         event_hit_o
);

  // A transaction accepted while no result is waiting.
  logic acc_empty;
  assign acc_empty = in_valid_i && in_ready_o && !out_valid_o;

  // A stalled result keeps its value.
  `MKPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(event_hit_o))

  // Input back-pressure only happens while results are waiting.
  `MKPD_ASSERT_NOW(a_stall_has_result, !in_ready_o, out_valid_o)

  // A transaction accepted into an empty buffer shows up in the next cycle.
  `MKPD_ASSERT_NEXT(a_result_latency, acc_empty, out_valid_o)

  // Scan and clear transactions never report a hit.
  `MKPD_ASSERT_NEXT(a_non_query_zero, acc_empty && action_i != mkpd_pkg::ACT_QUERY, !event_hit_o)

endmodule

bind multi_key_press_event_detector_unit mkpd_checker u_mkpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_hit_o (event_hit_o)
);
